FILE: src/segment_self_intersection_finder_top_macros.svh
// Assertion macros for the segment self-intersection finder.
// Used by the top level and the crossing divider; no other dependencies.
`ifndef SEGMENT_SELF_INTERSECTION_FINDER_TOP_MACROS_SVH
`define SEGMENT_SELF_INTERSECTION_FINDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SSIF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssif: implication check failed");
`define SSIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssif: next-cycle check failed");
`else
`define SSIF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSIF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/ssif_pkg.sv
// Package of the segment self-intersection finder: widths, codes and types.
// No dependencies.
`timescale 1ns / 1ps
package ssif_pkg;
   localparam int CW        = 24;
   localparam int MAX_SEG   = 32;
   localparam int DW        = CW + 1;
   localparam int PW        = 2 * DW;
   localparam int NW        = PW;
   localparam int RW        = NW + 1;
   localparam int QW        = CW + 1;
   localparam int BW        = CW + 2;
   localparam int CNT_W     = $clog2(MAX_SEG + 1);
   localparam int IDX_W     = $clog2(MAX_SEG);
   localparam int LINE_W    = 24;
   localparam int THR_W     = 23;
   localparam int LIM_W     = 6;
   localparam int ZCW       = (DW > THR_W) ? DW : THR_W;
   localparam int CMPW      = (CNT_W > LIM_W) ? CNT_W : LIM_W;
   localparam int DCNT_W    = $clog2(CW + 1);
   localparam int MIN_LEN   = 100;
   localparam int SQ_W      = 15;
   localparam int MIN_LEN_SQ = MIN_LEN * MIN_LEN;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);
   localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(32);

   localparam logic [0:0] CSR_Z_THRESHOLD  = 1'b0;
   localparam logic [0:0] CSR_MAX_SEGMENTS = 1'b1;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_type;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic signed [CW-1:0] sz;
      logic signed [CW-1:0] ez;
      logic [LINE_W-1:0]    line;
      logic                 rapid;
   } seg_type;

   typedef struct packed {
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic [LINE_W-1:0]    line;
      logic                 rapid;
      logic                 skip;
   } meta_type;

   typedef struct packed {
      logic [NW-1:0]        den;
      logic [NW-1:0]        tnum;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic [LINE_W-1:0]    line;
      logic                 rapid;
   } hit_type;

   typedef struct packed {
      logic adv;
      logic feed;
   } pipe_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage

FILE: src/segment_self_intersection_finder_top.sv
// Top level of the segment self-intersection finder: move intake, segment ring,
// scan sequencer and result output. Depends on ssif_pkg, ssif_cell, ssif_test, ssif_div.
`timescale 1ns / 1ps
`include "segment_self_intersection_finder_top_macros.svh"
// Use of the block:
//  - Moves enter on req_*: a word is taken when req_start is high and req_busy low.
//    req_op high begins a new path (segments cleared, previous point to origin).
//  - Hits leave on rsp_*: rsp_valid is high for one cycle per hit, in ascending
//    order of the earlier segment; rsp_last_hit marks the final hit of a move.
//    The receiver cannot stall; every strobed word must be taken.
//  - Registers are written on csr_*: index 0 z_threshold, index 1 max_segments.
//    csr_ready is always high; write only while req_busy is low.
// Busy behaviour and reset:
//  - A new-path command, a short move or a move with the store full leaves
//    req_busy low.
//  - A move that is stored behind two or more earlier segments rotates the
//    segment ring once round: req_busy stays high through the rotation, the
//    drain of the test pipeline and every stall of the crossing divider for a
//    hit found.
//  - Reset (synchronous) empties the store, puts the previous point at the
//    origin and restores z_threshold 500 and max_segments 32.
module segment_self_intersection_finder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   output logic                                req_busy,
   input  logic                                req_op,
   input  logic signed [ssif_pkg::CW-1:0]      req_pos_x,
   input  logic signed [ssif_pkg::CW-1:0]      req_pos_y,
   input  logic signed [ssif_pkg::CW-1:0]      req_pos_z,
   input  logic                                req_rapid_move,
   input  logic [ssif_pkg::LINE_W-1:0]         req_source_line,
   output logic                                rsp_valid,
   output logic [ssif_pkg::LINE_W-1:0]         rsp_line_first,
   output logic [ssif_pkg::LINE_W-1:0]         rsp_line_second,
   output logic signed [ssif_pkg::CW-1:0]      rsp_cross_x,
   output logic signed [ssif_pkg::CW-1:0]      rsp_cross_y,
   output logic                                rsp_severity_warning,
   output logic                                rsp_last_hit,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_index,
   input  logic [ssif_pkg::THR_W-1:0]          csr_wdata
);
   localparam int CW      = ssif_pkg::CW;
   localparam int DW      = ssif_pkg::DW;
   localparam int MAX_SEG = ssif_pkg::MAX_SEG;
   localparam int CNT_W   = ssif_pkg::CNT_W;
   localparam int IDX_W   = ssif_pkg::IDX_W;
   localparam int CMPW    = ssif_pkg::CMPW;
   localparam int LINE_W  = ssif_pkg::LINE_W;
   localparam int SQ_W    = ssif_pkg::SQ_W;

   // configuration
   logic [ssif_pkg::THR_W-1:0] thr_ff;
   logic [ssif_pkg::LIM_W-1:0] lim_ff;

   // path state
   logic signed [CW-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [CNT_W-1:0] cnt_ff;

   // scan sequencer
   ssif_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] rot_ff, nm1_ff;
   logic signed [CW-1:0] q3x_ff, q3y_ff, q3z_ff, q4x_ff, q4y_ff, q4z_ff;
   logic [LINE_W-1:0] line_ff;
   logic rapid_ff;

   // result path
   logic [LINE_W-1:0] meta_line_ff, pend_line_ff;
   logic meta_rapid_ff, pend_warn_ff, pend_valid_ff;
   logic signed [CW-1:0] pend_x_ff, pend_y_ff;
   logic rsp_valid_ff, rsp_last_ff, rsp_warn_ff;
   logic [LINE_W-1:0] rsp_l1_ff, rsp_l2_ff;
   logic signed [CW-1:0] rsp_x_ff, rsp_y_ff;

   logic accept, store, formed, drained, div_start, shift_en, emit_last;
   logic signed [DW-1:0] dx, dy;
   logic [DW-1:0] ax, ay;
   logic [SQ_W-1:0] len_sq;
   logic [CMPW-1:0] limit;
   ssif_pkg::seg_type new_seg;
   ssif_pkg::seg_type ring_q [MAX_SEG];
   ssif_pkg::pipe_ctl_type ctl;
   ssif_pkg::hit_type hit;
   ssif_pkg::div_stat_type dstat;
   logic hit_valid, pipe_busy;
   logic signed [CW-1:0] cx, cy;

   assign req_busy  = (state_ff != ssif_pkg::ST_IDLE);
   assign accept    = req_start && !req_busy;
   assign csr_ready = 1'b1;

   // length test of the new move in XY
   always_comb begin
      dx = DW'(req_pos_x) - DW'(prev_x_ff);
      dy = DW'(req_pos_y) - DW'(prev_y_ff);
      ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
      len_sq = SQ_W'(ax[6:0] * ax[6:0]) + SQ_W'(ay[6:0] * ay[6:0]);
      formed = (ax > DW'(ssif_pkg::MIN_LEN)) || (ay > DW'(ssif_pkg::MIN_LEN)) ||
               (len_sq > SQ_W'(ssif_pkg::MIN_LEN_SQ));
      limit = (CMPW'(lim_ff) > CMPW'(MAX_SEG)) ? CMPW'(MAX_SEG) : CMPW'(lim_ff);
      store = !req_op && formed && (CMPW'(cnt_ff) < limit);
      new_seg.sx = prev_x_ff;
      new_seg.sy = prev_y_ff;
      new_seg.ex = req_pos_x;
      new_seg.ey = req_pos_y;
      new_seg.sz = prev_z_ff;
      new_seg.ez = req_pos_z;
      new_seg.line = req_source_line;
      new_seg.rapid = req_rapid_move;
   end

   // segment ring: cell 0 is the head seen by the test pipeline; rotate towards it
   assign ctl.adv  = !dstat.busy;
   assign ctl.feed = (state_ff == ssif_pkg::ST_SCAN) && (rot_ff < nm1_ff);
   assign shift_en = (state_ff == ssif_pkg::ST_SCAN) && ctl.adv;

   for (genvar i = 0; i < MAX_SEG; i++) begin : g_ring
      ssif_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .wr_en    (accept && store && (cnt_ff[IDX_W-1:0] == IDX_W'(i))),
         .wr_seg   (new_seg),
         .nb_seg   (ring_q[(i + 1) % MAX_SEG]),
         .seg_o    (ring_q[i])
      );
   end

   ssif_test u_test (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .seg_i       (ring_q[0]),
      .p3x         (q3x_ff),
      .p3y         (q3y_ff),
      .p3z         (q3z_ff),
      .p4x         (q4x_ff),
      .p4y         (q4y_ff),
      .p4z         (q4z_ff),
      .thr         (thr_ff),
      .hit_valid_o (hit_valid),
      .hit_o       (hit),
      .busy_o      (pipe_busy)
   );

   assign div_start = hit_valid && ctl.adv;

   ssif_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start_i (div_start),
      .hit_i   (hit),
      .cx_o    (cx),
      .cy_o    (cy),
      .stat_o  (dstat)
   );

   assign drained = !pipe_busy && !dstat.busy && !dstat.done;

   // sequencer: a full turn of the ring, then drain pipeline and divider
   always_comb begin
      state_in  = state_ff;
      emit_last = 1'b0;
      case (state_ff)
         ssif_pkg::ST_IDLE: begin
            if (accept && store && (cnt_ff >= CNT_W'(2))) state_in = ssif_pkg::ST_SCAN;
         end
         ssif_pkg::ST_SCAN: begin
            if (ctl.adv && (rot_ff == CNT_W'(MAX_SEG - 1))) state_in = ssif_pkg::ST_DRAIN;
         end
         ssif_pkg::ST_DRAIN: begin
            if (drained) begin
               state_in  = ssif_pkg::ST_IDLE;
               emit_last = pend_valid_ff;
            end
         end
         default: state_in = ssif_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssif_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration words
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ssif_pkg::THR_RESET;
         lim_ff <= ssif_pkg::LIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ssif_pkg::CSR_Z_THRESHOLD:  thr_ff <= csr_wdata;
            ssif_pkg::CSR_MAX_SEGMENTS: lim_ff <= csr_wdata[ssif_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // path state and scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_z_ff <= '0;
         cnt_ff    <= '0;
         rot_ff    <= '0;
         nm1_ff    <= '0;
      end else begin
         if (accept) begin
            rot_ff <= '0;
            nm1_ff <= cnt_ff - CNT_W'(1);
            if (req_op) begin
               prev_x_ff <= '0;
               prev_y_ff <= '0;
               prev_z_ff <= '0;
               cnt_ff    <= '0;
            end else begin
               prev_x_ff <= req_pos_x;
               prev_y_ff <= req_pos_y;
               prev_z_ff <= req_pos_z;
               if (store) cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end else if (shift_en) begin
            rot_ff <= rot_ff + CNT_W'(1);
         end
      end
   end

   // hold the new segment for the test pipeline
   always_ff @(posedge clock) begin
      if (accept) begin
         q3x_ff   <= prev_x_ff;
         q3y_ff   <= prev_y_ff;
         q3z_ff   <= prev_z_ff;
         q4x_ff   <= req_pos_x;
         q4y_ff   <= req_pos_y;
         q4z_ff   <= req_pos_z;
         line_ff  <= req_source_line;
         rapid_ff <= req_rapid_move;
      end
      if (div_start) begin
         meta_line_ff  <= hit.line;
         meta_rapid_ff <= hit.rapid;
      end
   end

   // one hit waits in the pending word so the last one can be marked
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (dstat.done) begin
            rsp_valid_ff  <= pend_valid_ff;
            pend_valid_ff <= 1'b1;
         end else if (emit_last) begin
            rsp_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dstat.done || emit_last) begin
         rsp_l1_ff   <= pend_line_ff;
         rsp_l2_ff   <= line_ff;
         rsp_x_ff    <= pend_x_ff;
         rsp_y_ff    <= pend_y_ff;
         rsp_warn_ff <= pend_warn_ff;
         rsp_last_ff <= emit_last;
      end
      if (dstat.done) begin
         pend_line_ff <= meta_line_ff;
         pend_warn_ff <= meta_rapid_ff | rapid_ff;
         pend_x_ff    <= cx;
         pend_y_ff    <= cy;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_line_first       = rsp_l1_ff;
   assign rsp_line_second      = rsp_l2_ff;
   assign rsp_cross_x          = rsp_x_ff;
   assign rsp_cross_y          = rsp_y_ff;
   assign rsp_severity_warning = rsp_warn_ff;
   assign rsp_last_hit         = rsp_last_ff;

   `SSIF_ASSERT_IMPL(a_rot_range, clock, reset, state_ff == ssif_pkg::ST_SCAN,
                     rot_ff < CNT_W'(MAX_SEG))
   `SSIF_ASSERT_IMPL(a_mid_hit_busy, clock, reset, rsp_valid_ff && !rsp_last_ff,
                     state_ff != ssif_pkg::ST_IDLE)
   `SSIF_ASSERT_IMPL(a_div_in_scan, clock, reset, div_start, state_ff != ssif_pkg::ST_IDLE)
endmodule

FILE: src/ssif_cell.sv
// One cell of the segment ring: holds a stored segment.
// Depends on ssif_pkg.
`timescale 1ns / 1ps
module ssif_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  logic             wr_en,
   input  ssif_pkg::seg_type wr_seg,
   input  ssif_pkg::seg_type nb_seg,
   output ssif_pkg::seg_type seg_o
);
   ssif_pkg::seg_type seg_ff, seg_in;

   always_comb begin
      seg_in = seg_ff;
      if (wr_en) begin
         seg_in = wr_seg;
      end else if (shift_en) begin
         seg_in = nb_seg;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign seg_o = seg_ff;
endmodule

FILE: src/ssif_test.sv
// Four-stage crossing test pipeline fed from the head of the segment ring.
// Depends on ssif_pkg.
`timescale 1ns / 1ps
module ssif_test (
   input  logic                           clock,
   input  logic                           reset,
   input  ssif_pkg::pipe_ctl_type         ctl,
   input  ssif_pkg::seg_type              seg_i,
   input  logic signed [ssif_pkg::CW-1:0] p3x,
   input  logic signed [ssif_pkg::CW-1:0] p3y,
   input  logic signed [ssif_pkg::CW-1:0] p3z,
   input  logic signed [ssif_pkg::CW-1:0] p4x,
   input  logic signed [ssif_pkg::CW-1:0] p4y,
   input  logic signed [ssif_pkg::CW-1:0] p4z,
   input  logic [ssif_pkg::THR_W-1:0]     thr,
   output logic                           hit_valid_o,
   output ssif_pkg::hit_type              hit_o,
   output logic                           busy_o
);
   localparam int DW = ssif_pkg::DW;
   localparam int PW = ssif_pkg::PW;
   localparam int NW = ssif_pkg::NW;
   localparam int ZCW = ssif_pkg::ZCW;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [DW-1:0] a_ff, b_ff, c_ff, e_ff, f_ff, g_ff;
   logic signed [DW-1:0] a_in, b_in, c_in, e_in, f_in, g_in;
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [NW-1:0] d_ff, tn_ff, un_ff;
   logic signed [NW-1:0] dn_ff, tnn_ff, unn_ff, dn_in, tnn_in, unn_in;
   ssif_pkg::meta_type m1_ff, m2_ff, m3_ff, m4_ff, m1_in;
   logic signed [DW-1:0] dz0, dz1;
   logic [DW-1:0] az0, az1;

   // stage 1: differences and the layer check
   always_comb begin
      a_in = DW'(seg_i.sx) - DW'(seg_i.ex);
      b_in = DW'(p3y) - DW'(p4y);
      c_in = DW'(seg_i.sy) - DW'(seg_i.ey);
      e_in = DW'(p3x) - DW'(p4x);
      f_in = DW'(seg_i.sx) - DW'(p3x);
      g_in = DW'(seg_i.sy) - DW'(p3y);
      dz0 = DW'(seg_i.sz) - DW'(p3z);
      dz1 = DW'(seg_i.ez) - DW'(p4z);
      az0 = dz0[DW-1] ? DW'(-dz0) : DW'(dz0);
      az1 = dz1[DW-1] ? DW'(-dz1) : DW'(dz1);
      m1_in.x1 = seg_i.sx;
      m1_in.y1 = seg_i.sy;
      m1_in.dx = DW'(seg_i.ex) - DW'(seg_i.sx);
      m1_in.dy = DW'(seg_i.ey) - DW'(seg_i.sy);
      m1_in.line = seg_i.line;
      m1_in.rapid = seg_i.rapid;
      m1_in.skip = (ZCW'(az0) > ZCW'(thr)) && (ZCW'(az1) > ZCW'(thr));
   end

   // stage 4: normalise so that the denominator is positive
   always_comb begin
      dn_in  = d_ff[NW-1] ? -d_ff  : d_ff;
      tnn_in = d_ff[NW-1] ? -tn_ff : tn_ff;
      unn_in = d_ff[NW-1] ? -un_ff : un_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (ctl.adv) begin
         v1_ff <= ctl.feed;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
         e_ff <= e_in; f_ff <= f_in; g_ff <= g_in;
         m1_ff <= m1_in;
         p1_ff <= PW'(a_ff) * PW'(b_ff);
         p2_ff <= PW'(c_ff) * PW'(e_ff);
         p3_ff <= PW'(f_ff) * PW'(b_ff);
         p4_ff <= PW'(g_ff) * PW'(e_ff);
         p5_ff <= PW'(c_ff) * PW'(f_ff);
         p6_ff <= PW'(a_ff) * PW'(g_ff);
         m2_ff <= m1_ff;
         d_ff  <= NW'(p1_ff) - NW'(p2_ff);
         tn_ff <= NW'(p3_ff) - NW'(p4_ff);
         un_ff <= NW'(p5_ff) - NW'(p6_ff);
         m3_ff <= m2_ff;
         dn_ff <= dn_in; tnn_ff <= tnn_in; unn_ff <= unn_in;
         m4_ff <= m3_ff;
      end
   end

   assign hit_valid_o = v4_ff && !m4_ff.skip && (dn_ff != '0) && !tnn_ff[NW-1] &&
                        !unn_ff[NW-1] && (tnn_ff <= dn_ff) && (unn_ff <= dn_ff);
   assign hit_o.den   = NW'(unsigned'(dn_ff));
   assign hit_o.tnum  = NW'(unsigned'(tnn_ff));
   assign hit_o.x1    = m4_ff.x1;
   assign hit_o.y1    = m4_ff.y1;
   assign hit_o.dx    = m4_ff.dx;
   assign hit_o.dy    = m4_ff.dy;
   assign hit_o.line  = m4_ff.line;
   assign hit_o.rapid = m4_ff.rapid;
   assign busy_o = v1_ff | v2_ff | v3_ff | v4_ff;
endmodule

FILE: src/ssif_div.sv
// Crossing point unit: radix-2 product-and-divide, one bit a cycle, X and Y lanes.
// Depends on ssif_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "segment_self_intersection_finder_top_macros.svh"
module ssif_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start_i,
   input  ssif_pkg::hit_type               hit_i,
   output logic signed [ssif_pkg::CW-1:0]  cx_o,
   output logic signed [ssif_pkg::CW-1:0]  cy_o,
   output ssif_pkg::div_stat_type          stat_o
);
   localparam int CW = ssif_pkg::CW;
   localparam int NW = ssif_pkg::NW;
   localparam int RW = ssif_pkg::RW;
   localparam int QW = ssif_pkg::QW;
   localparam int BW = ssif_pkg::BW;
   localparam int DCNT_W = ssif_pkg::DCNT_W;

   logic busy_ff, done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [NW-1:0] den_ff, tn_ff;
   logic [CW-1:0] magx_ff, magy_ff;
   logic negx_ff, negy_ff;
   logic signed [CW-1:0] x1_ff, y1_ff, cx_ff, cy_ff;
   logic [RW-1:0] remx_ff, remy_ff;
   logic [QW-1:0] qx_ff, qy_ff;
   logic [RW+1:0] stx, sty;
   logic [CW-1:0] absx, absy;

   // one step: rem = 2 rem + bit * tn, then take out up to two denominators
   function automatic logic [RW+1:0] div_step(logic [RW-1:0] rem, logic bit_in,
                                              logic [NW-1:0] tn, logic [NW-1:0] d);
      logic [RW:0] t, d1, d2;
      logic [1:0] dig;
      t  = {rem, 1'b0} + (bit_in ? (RW+1)'(tn) : '0);
      d1 = (RW+1)'(d);
      d2 = {d1[RW-1:0], 1'b0};
      dig = 2'd0;
      if (t >= d2) begin
         t = t - d2;
         dig = 2'd2;
      end else if (t >= d1) begin
         t = t - d1;
         dig = 2'd1;
      end
      return {t[RW-1:0], dig};
   endfunction

   // base = x1 +/- q, then round the leftover r/d with ties away from zero
   function automatic logic signed [CW-1:0] round_fn(logic signed [CW-1:0] x1, logic neg,
                                                     logic [QW-1:0] q, logic [RW-1:0] r,
                                                     logic [NW-1:0] d);
      logic signed [BW-1:0] base, qs, res;
      logic [RW:0] r2, dd;
      logic gt, eq;
      qs = $signed({1'b0, q});
      base = neg ? (BW'(x1) - qs) : (BW'(x1) + qs);
      r2 = {r, 1'b0};
      dd = (RW+1)'(d);
      gt = r2 > dd;
      eq = r2 == dd;
      res = base;
      if (!neg) begin
         if (gt || (eq && !base[BW-1])) res = base + BW'(1);
      end else begin
         if (gt || (eq && (base <= 0))) res = base - BW'(1);
      end
      return res[CW-1:0];
   endfunction

   assign stx = div_step(remx_ff, magx_ff[CW-1], tn_ff, den_ff);
   assign sty = div_step(remy_ff, magy_ff[CW-1], tn_ff, den_ff);
   assign absx = hit_i.dx[CW] ? CW'(-hit_i.dx) : hit_i.dx[CW-1:0];
   assign absy = hit_i.dy[CW] ? CW'(-hit_i.dy) : hit_i.dy[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start_i) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(CW);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - DCNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_i) begin
         den_ff  <= hit_i.den;
         tn_ff   <= hit_i.tnum;
         magx_ff <= absx;
         magy_ff <= absy;
         negx_ff <= hit_i.dx[CW];
         negy_ff <= hit_i.dy[CW];
         x1_ff   <= hit_i.x1;
         y1_ff   <= hit_i.y1;
         remx_ff <= '0;
         remy_ff <= '0;
         qx_ff   <= '0;
         qy_ff   <= '0;
      end else if (busy_ff && (cnt_ff != '0)) begin
         magx_ff <= {magx_ff[CW-2:0], 1'b0};
         magy_ff <= {magy_ff[CW-2:0], 1'b0};
         remx_ff <= stx[RW+1:2];
         remy_ff <= sty[RW+1:2];
         qx_ff   <= {qx_ff[QW-2:0], 1'b0} + QW'(stx[1:0]);
         qy_ff   <= {qy_ff[QW-2:0], 1'b0} + QW'(sty[1:0]);
      end else if (busy_ff) begin
         cx_ff <= round_fn(x1_ff, negx_ff, qx_ff, remx_ff, den_ff);
         cy_ff <= round_fn(y1_ff, negy_ff, qy_ff, remy_ff, den_ff);
      end
   end

   assign cx_o = cx_ff;
   assign cy_o = cy_ff;
   assign stat_o.busy = busy_ff;
   assign stat_o.done = done_ff;

   `SSIF_ASSERT_IMPL(a_no_restart, clock, reset, start_i, !busy_ff)
   `SSIF_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)
   `SSIF_ASSERT_IMPL(a_cnt_range, clock, reset, busy_ff, cnt_ff <= DCNT_W'(CW))
endmodule

FILE: tb/sv/segment_self_intersection_finder_checker.sv
// Checker for the segment self-intersection finder: watches the move, hit and
// register channels, predicts every hit and compares. Depends on ssif_pkg.
`timescale 1ns / 1ps
module segment_self_intersection_finder_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_start,
   input  logic                           req_busy,
   input  logic                           req_op,
   input  logic signed [ssif_pkg::CW-1:0] req_pos_x,
   input  logic signed [ssif_pkg::CW-1:0] req_pos_y,
   input  logic signed [ssif_pkg::CW-1:0] req_pos_z,
   input  logic                           req_rapid_move,
   input  logic [ssif_pkg::LINE_W-1:0]    req_source_line,
   input  logic                           rsp_valid,
   input  logic [ssif_pkg::LINE_W-1:0]    rsp_line_first,
   input  logic [ssif_pkg::LINE_W-1:0]    rsp_line_second,
   input  logic signed [ssif_pkg::CW-1:0] rsp_cross_x,
   input  logic signed [ssif_pkg::CW-1:0] rsp_cross_y,
   input  logic                           rsp_severity_warning,
   input  logic                           rsp_last_hit,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [0:0]                     csr_index,
   input  logic [ssif_pkg::THR_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             hits_pending
);
   typedef struct packed {
      logic [ssif_pkg::LINE_W-1:0]    line_first;
      logic [ssif_pkg::LINE_W-1:0]    line_second;
      logic signed [ssif_pkg::CW-1:0] cross_x;
      logic signed [ssif_pkg::CW-1:0] cross_y;
      logic                           warning;
      logic                           last_hit;
   } hit_word_type;

   typedef struct {
      longint sx, sy, ex, ey, sz, ez;
      logic [ssif_pkg::LINE_W-1:0] line;
      logic rapid;
   } stored_seg_type;

   hit_word_type   hit_queue[$];
   stored_seg_type seg_store[ssif_pkg::MAX_SEG];
   int             seg_total;
   longint         last_x, last_y, last_z;
   longint         z_limit;
   int             seg_limit;

   function automatic longint round_div(logic signed [127:0] num, logic signed [127:0] den);
      logic signed [127:0] mag;
      logic signed [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return 64'((num < 0) ? -q : q);
   endfunction

   function automatic longint mag64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic report(string what, longint want, longint got);
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
      fail_count++;
   endtask

   // Work out the hits of one accepted move and advance the path state.
   task automatic predict_move(logic op, longint x, longint y, longint z,
                               logic rapid, logic [ssif_pkg::LINE_W-1:0] line);
      longint dx, dy, d, tn, un, x1, y1, x2, y2;
      int n, lim, first_new;
      logic signed [127:0] nx, ny;
      hit_word_type h;
      if (op) begin
         seg_total = 0;
         last_x = 0; last_y = 0; last_z = 0;
         return;
      end
      dx = mag64(x - last_x);
      dy = mag64(y - last_y);
      lim = (seg_limit > ssif_pkg::MAX_SEG) ? ssif_pkg::MAX_SEG : seg_limit;
      n = seg_total;
      first_new = hit_queue.size();
      if ((dx > ssif_pkg::MIN_LEN || dy > ssif_pkg::MIN_LEN ||
           dx * dx + dy * dy > ssif_pkg::MIN_LEN_SQ) && n < lim) begin
         seg_store[n] = '{last_x, last_y, x, y, last_z, z, line, rapid};
         seg_total = n + 1;
         for (int k = 0; k + 1 < n; k++) begin
            if (mag64(seg_store[k].sz - last_z) > z_limit &&
                mag64(seg_store[k].ez - z) > z_limit)
               continue;
            x1 = seg_store[k].sx; y1 = seg_store[k].sy;
            x2 = seg_store[k].ex; y2 = seg_store[k].ey;
            d  = (x1 - x2) * (last_y - y) - (y1 - y2) * (last_x - x);
            if (d == 0)
               continue;
            tn = (x1 - last_x) * (last_y - y) - (y1 - last_y) * (last_x - x);
            un = (y1 - y2) * (x1 - last_x) - (x1 - x2) * (y1 - last_y);
            if (d < 0) begin
               d = -d; tn = -tn; un = -un;
            end
            if (tn < 0 || un < 0 || tn > d || un > d)
               continue;
            nx = 128'(d) * 128'(x1) + 128'(tn) * 128'(x2 - x1);
            ny = 128'(d) * 128'(y1) + 128'(tn) * 128'(y2 - y1);
            h.line_first  = seg_store[k].line;
            h.line_second = line;
            h.cross_x     = ssif_pkg::CW'(round_div(nx, 128'(d)));
            h.cross_y     = ssif_pkg::CW'(round_div(ny, 128'(d)));
            h.warning     = seg_store[k].rapid | rapid;
            h.last_hit    = 1'b0;
            hit_queue.insert(hit_queue.size(), h);
         end
         if (hit_queue.size() > first_new)
            hit_queue[hit_queue.size() - 1].last_hit = 1'b1;
      end
      last_x = x; last_y = y; last_z = z;
   endtask

   always @(posedge clock) begin
      hit_word_type w;
      if (reset) begin
         hit_queue.delete();
         seg_total = 0;
         last_x = 0; last_y = 0; last_z = 0;
         z_limit = 500;
         seg_limit = 32;
         fail_count = 0;
         hits_pending = 0;
      end else begin
         if (rsp_valid) begin
            if (hit_queue.size() == 0) begin
               report("unexpected hit word, line_second", 0, longint'(rsp_line_second));
            end else begin
               w = hit_queue.pop_front();
               if (rsp_line_first !== w.line_first)
                  report("line_first", longint'(w.line_first), longint'(rsp_line_first));
               if (rsp_line_second !== w.line_second)
                  report("line_second", longint'(w.line_second), longint'(rsp_line_second));
               if (rsp_cross_x !== w.cross_x)
                  report("cross_x", longint'(w.cross_x), longint'(rsp_cross_x));
               if (rsp_cross_y !== w.cross_y)
                  report("cross_y", longint'(w.cross_y), longint'(rsp_cross_y));
               if (rsp_severity_warning !== w.warning)
                  report("severity_warning", longint'(w.warning),
                         longint'(rsp_severity_warning));
               if (rsp_last_hit !== w.last_hit)
                  report("last_hit", longint'(w.last_hit), longint'(rsp_last_hit));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == ssif_pkg::CSR_Z_THRESHOLD)
               z_limit = longint'(csr_wdata);
            else
               seg_limit = int'(csr_wdata[ssif_pkg::LIM_W-1:0]);
         end
         if (req_start && !req_busy)
            predict_move(req_op, longint'(req_pos_x), longint'(req_pos_y),
                         longint'(req_pos_z), req_rapid_move, req_source_line);
         hits_pending = hit_queue.size();
      end
   end
endmodule

FILE: tb/sv/segment_self_intersection_finder_top_tb.sv
// Testbench top for the segment self-intersection finder: clock, reset, move
// and register stimulus, watchdog and verdict. Depends on ssif_pkg, the block
// and segment_self_intersection_finder_checker.
`timescale 1ns / 1ps
module segment_self_intersection_finder_top_tb;
   // Cycles of silence on every channel before the run is declared hung.
   localparam int STALL_LIMIT = 5000;
   // Settle time after the last hit: one full ring rotation plus drain.
   localparam int SETTLE_CYCLES = 48;

   logic                                clock;
   logic                                reset;
   logic                                req_start;
   logic                                req_busy;
   logic                                req_op;
   logic signed [ssif_pkg::CW-1:0]      req_pos_x, req_pos_y, req_pos_z;
   logic                                req_rapid_move;
   logic [ssif_pkg::LINE_W-1:0]         req_source_line;
   logic                                rsp_valid;
   logic [ssif_pkg::LINE_W-1:0]         rsp_line_first, rsp_line_second;
   logic signed [ssif_pkg::CW-1:0]      rsp_cross_x, rsp_cross_y;
   logic                                rsp_severity_warning, rsp_last_hit;
   logic                                csr_valid, csr_ready;
   logic [0:0]                          csr_index;
   logic [ssif_pkg::THR_W-1:0]          csr_wdata;
   int                                  fail_count, hits_pending;
   int                                  idle_pct;
   int                                  quiet_cycles;
   logic [ssif_pkg::LINE_W-1:0]         line_no;

   segment_self_intersection_finder_top dut (.*);

   segment_self_intersection_finder_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: count cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_start && !req_busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Present one move word and hold it until the block takes it. Optionally
   // idle first, so gaps land on every phase of the scan.
   task automatic send_move(logic op, int x, int y, int z, logic rapid);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_start <= 1'b0;
         @(negedge clock);
      end
      req_start       <= 1'b1;
      req_op          <= op;
      req_pos_x       <= ssif_pkg::CW'(x);
      req_pos_y       <= ssif_pkg::CW'(y);
      req_pos_z       <= ssif_pkg::CW'(z);
      req_rapid_move  <= rapid;
      req_source_line <= line_no;
      line_no = line_no + ssif_pkg::LINE_W'(1);
      do @(posedge clock); while (req_busy);
   endtask

   // Hold the sender until every expected hit has come and the ring is idle.
   task automatic drain_hits();
      @(negedge clock);
      req_start <= 1'b0;
      while (hits_pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] index, int value);
      drain_hits();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= ssif_pkg::THR_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random move: mostly a path wandering in a small box so that crossings are
   // frequent; now and then a short hop, a full-range jump or a new path.
   task automatic random_move();
      int pick;
      int x, y, z;
      pick = int'($urandom_range(99));
      x = int'($urandom_range(6000)) - 3000;
      y = int'($urandom_range(6000)) - 3000;
      z = int'($urandom_range(1600)) - 800;
      if (pick < 4) begin
         send_move(1'b1, int'($urandom), int'($urandom), int'($urandom),
                   1'($urandom_range(1)));
      end else if (pick < 12) begin
         send_move(1'b0, int'($urandom), int'($urandom), int'($urandom),
                   1'($urandom_range(1)));
      end else if (pick < 18) begin
         // short hop relative to the last point sent
         send_move(1'b0, int'(req_pos_x) + int'($urandom_range(140)) - 70,
                   int'(req_pos_y) + int'($urandom_range(140)) - 70, z,
                   1'($urandom_range(1)));
      end else begin
         send_move(1'b0, x, y, z, ($urandom_range(4) == 0));
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_start       = 1'b0;
      req_op          = 1'b0;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pos_z       = '0;
      req_rapid_move  = 1'b0;
      req_source_line = '0;
      csr_valid       = 1'b0;
      csr_index       = ssif_pkg::CSR_Z_THRESHOLD;
      csr_wdata       = '0;
      idle_pct        = 0;
      line_no         = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: a bow-tie crossing, a short move, rapid severity, parallel
      // and collinear segments, a new path, then full-scale diagonals.
      send_move(1'b0, 1000, 1000, 0, 1'b0);
      send_move(1'b0, 1000, 0, 0, 1'b0);
      send_move(1'b0, 0, 1000, 0, 1'b1);
      send_move(1'b0, 50, 1050, 0, 1'b0);
      send_move(1'b0, 50, 0, 0, 1'b0);
      send_move(1'b0, 700, 1300, 0, 1'b0);
      send_move(1'b0, -500, -500, 0, 1'b0);
      send_move(1'b0, 1500, 1500, 0, 1'b0);
      send_move(1'b1, 0, 0, 0, 1'b0);
      line_no = '1;
      send_move(1'b0, 8388607, 8388607, 8388607, 1'b1);
      send_move(1'b0, 8388607, -8388608, -8388608, 1'b0);
      send_move(1'b0, -8388608, 8388607, 8388607, 1'b0);
      send_move(1'b0, -8388608, -8388608, -8388608, 1'b1);
      send_move(1'b0, 8388607, 0, 0, 1'b0);
      send_move(1'b1, -1, -1, -1, 1'b1);
      // layer check: the third segment ends far above the first in Z but starts at its height
      send_move(1'b0, 1000, 1000, 0, 1'b0);
      send_move(1'b0, 1000, 0, 0, 1'b0);
      send_move(1'b0, 0, 1000, 5000, 1'b0);
      send_move(1'b0, 3, 7, 0, 1'b0);

      // Random phases through several register settings, extremes among them.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(ssif_pkg::CSR_Z_THRESHOLD, 0);
               write_reg(ssif_pkg::CSR_MAX_SEGMENTS, 32);
               idle_pct = 0;
            end
            1: begin
               write_reg(ssif_pkg::CSR_Z_THRESHOLD, 'h7FFFFF);
               write_reg(ssif_pkg::CSR_MAX_SEGMENTS, 63);
               idle_pct = 46;
            end
            2: begin
               write_reg(ssif_pkg::CSR_Z_THRESHOLD, 300);
               write_reg(ssif_pkg::CSR_MAX_SEGMENTS, 4);
               idle_pct = 25;
            end
            3: begin
               write_reg(ssif_pkg::CSR_Z_THRESHOLD, 500);
               write_reg(ssif_pkg::CSR_MAX_SEGMENTS, 0);
               idle_pct = 46;
            end
            4: begin
               write_reg(ssif_pkg::CSR_MAX_SEGMENTS, 33);
               idle_pct = 25;
            end
            default: begin
               // lower the limit under an already filled store
               write_reg(ssif_pkg::CSR_MAX_SEGMENTS, 6);
               write_reg(ssif_pkg::CSR_Z_THRESHOLD, 'h3FF);
               idle_pct = 0;
            end
         endcase
         for (int i = 0; i < 27; i++) begin
            random_move();
            if (phase == 1 && i == 13)
               drain_hits();
         end
      end

      drain_hits();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
